FILE: rtl/wildcard_glob_matcher_core_defines.svh
// Assertion macros for the wildcard glob matcher checker.
// Needs clk and rst visible at the place of use.
`ifndef WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_CORE_DEFINES_SVH

// Same-cycle implication, off during reset.
`define WGM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wgm check failed");

// Next-cycle implication, off during reset.
`define WGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wgm check failed");

`endif

FILE: rtl/wgm_pkg.sv
// Shared constants for the wildcard glob matcher.
// No dependencies.
package wgm_pkg;

  localparam int PATTERN_CHARS_DEF = 64;
  localparam int NREGS             = 8;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam logic [7:0] STAR_CHAR  = 8'h2A;
  localparam logic [7:0] QMARK_CHAR = 8'h3F;

endpackage

FILE: rtl/wildcard_glob_matcher_core.sv
// Wildcard glob matcher top level: active-position update, verdict and
// output skid stage. Depends on wgm_pkg, wgm_pattern and wgm_close.
//
//   channel  dir  payload                                   transaction
//   s_*      in   tdata[7:0] text_byte, tuser has_byte,     one string byte
//                 tlast string_end
//   m_*      out  tdata[0] matched, [7:1] zero              one verdict
//   cfg_*    in   index 0..7, data 64 bit pattern word      one register write
//
// One byte per cycle while s_tready is high; the position update and
// closure sit in one register stage; the verdict is registered at the output.
// Reset is synchronous: pattern cleared, position zero active, no result.
// A stalled verdict moves to a one-entry skid; s_tready drops only while
// the skid holds a verdict. cfg_ready is always high.
module wildcard_glob_matcher_core
  import wgm_pkg::*;
#(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] text_byte
  input  logic                  s_tuser,   // [0] has_byte
  input  logic                  s_tlast,   // string_end
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // [0] matched, [7:1] zero
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NPOS = PATTERN_CHARS + 1;

  logic [PATTERN_CHARS-1:0][7:0] pat_byte;
  logic [PATTERN_CHARS-1:0]      is_star;
  logic [PATTERN_CHARS-1:0]      is_qmark;
  logic [PATTERN_CHARS-1:0]      in_pat;
  logic [NPOS-1:0]               end_pos;

  logic [NPOS-1:0]          active;
  logic [NPOS-1:0]          active_next;
  logic [PATTERN_CHARS-1:0] star_mask;
  logic [PATTERN_CHARS-1:0] step_ok;
  logic [PATTERN_CHARS-1:0] stay_ok;
  logic [NPOS-1:0]          clos_in;
  logic [NPOS-1:0]          moved;
  logic [NPOS-1:0]          after;
  logic [NPOS-1:0]          clos_out;
  logic                     verdict;
  logic                     accept;
  logic                     produce;

  logic skid_valid;
  logic skid_matched;
  logic out_matched;

  assign cfg_ready = 1'b1;

  wgm_pattern #(.PATTERN_CHARS(PATTERN_CHARS)) u_pattern (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pat_byte (pat_byte),
    .is_star  (is_star),
    .is_qmark (is_qmark),
    .in_pat   (in_pat),
    .end_pos  (end_pos)
  );

  assign star_mask = is_star & in_pat;

  for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_cmp
    assign stay_ok[i] = star_mask[i];
    assign step_ok[i] = in_pat[i] && !is_star[i] &&
                        (is_qmark[i] || (pat_byte[i] == s_tdata));
  end

  wgm_close #(.NPOS(NPOS)) u_close_in (
    .act (active),
    .star(star_mask),
    .clos(clos_in)
  );

  for (genvar j = 0; j < NPOS; j++) begin : g_move
    if (j == 0) begin : g_first
      assign moved[j] = clos_in[j] & stay_ok[j];
    end else if (j == PATTERN_CHARS) begin : g_last
      assign moved[j] = clos_in[j-1] & step_ok[j-1];
    end else begin : g_mid
      assign moved[j] = (clos_in[j] & stay_ok[j]) | (clos_in[j-1] & step_ok[j-1]);
    end
  end

  assign after = s_tuser ? moved : active;

  wgm_close #(.NPOS(NPOS)) u_close_out (
    .act (after),
    .star(star_mask),
    .clos(clos_out)
  );

  assign verdict  = |(clos_out & end_pos);
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign produce  = accept && s_tlast;

  always_comb begin
    active_next = active;
    if (accept) begin
      active_next = s_tlast ? NPOS'(1) : after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= NPOS'(1);
    end else begin
      active <= active_next;
    end
  end

  // Output register with one-entry skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= produce;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      out_matched <= skid_valid ? skid_matched : verdict;
    end
    if (!(m_tready || !m_tvalid) && produce) begin
      skid_matched <= verdict;
    end
  end

  assign m_tdata = {7'b0, out_matched};

endmodule

FILE: rtl/wgm_pattern.sv
// Pattern store: byte registers written by the config channel, plus per-byte
// star, question-mark and in-pattern flags. Depends on wgm_pkg.
module wgm_pattern
  import wgm_pkg::*;
#(
  parameter int PATTERN_CHARS = PATTERN_CHARS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  output logic [PATTERN_CHARS-1:0][7:0]       pat_byte,
  output logic [PATTERN_CHARS-1:0]            is_star,
  output logic [PATTERN_CHARS-1:0]            is_qmark,
  output logic [PATTERN_CHARS-1:0]            in_pat,
  output logic [PATTERN_CHARS:0]              end_pos
);

  logic [PATTERN_CHARS-1:0][7:0] byte_next;
  logic [PATTERN_CHARS-1:0]      nz_next;
  logic [PATTERN_CHARS-1:0]      in_pat_next;

  for (genvar i = 0; i < PATTERN_CHARS; i++) begin : g_byte
    localparam int WORD = i / 8;
    localparam int LANE = i % 8;
    always_comb begin
      byte_next[i] = pat_byte[i];
      if (cfg_valid && (cfg_index == CFG_IDX_W'(WORD))) begin
        byte_next[i] = cfg_data[LANE*8 +: 8];
      end
    end
    assign nz_next[i]     = (byte_next[i] != 8'h00);
    assign in_pat_next[i] = &nz_next[i:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        pat_byte[i] <= 8'h00;
        is_star[i]  <= 1'b0;
        is_qmark[i] <= 1'b0;
        in_pat[i]   <= 1'b0;
      end else begin
        pat_byte[i] <= byte_next[i];
        is_star[i]  <= (byte_next[i] == STAR_CHAR);
        is_qmark[i] <= (byte_next[i] == QMARK_CHAR);
        in_pat[i]   <= in_pat_next[i];
      end
    end
  end

  // One-hot marker of the pattern length.
  for (genvar j = 0; j <= PATTERN_CHARS; j++) begin : g_end
    if (j == 0) begin : g_first
      assign end_pos[j] = !in_pat[0];
    end else if (j == PATTERN_CHARS) begin : g_last
      assign end_pos[j] = in_pat[j-1];
    end else begin : g_mid
      assign end_pos[j] = in_pat[j-1] && !in_pat[j];
    end
  end

endmodule

FILE: rtl/wgm_close.sv
// Star closure over the active position vector, as a parallel prefix:
// a position on a star also activates the one after it. No dependencies.
module wgm_close #(
  parameter int NPOS = 65
) (
  input  logic [NPOS-1:0] act,
  input  logic [NPOS-2:0] star,
  output logic [NPOS-1:0] clos
);

  localparam int LEVELS = $clog2(NPOS);

  logic [NPOS-1:0] gen [LEVELS+1];
  logic [NPOS-1:0] prop [LEVELS];

  assign gen[0]  = act;
  assign prop[0] = {star, 1'b0};

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int D = 1 << (l - 1);
    for (genvar j = 0; j < NPOS; j++) begin : g_pos
      if (j >= D) begin : g_span
        assign gen[l][j] = gen[l-1][j] | (prop[l-1][j] & gen[l-1][j-D]);
        if (l < LEVELS) begin : g_p
          assign prop[l][j] = prop[l-1][j] & prop[l-1][j-D];
        end
      end else begin : g_pass
        assign gen[l][j] = gen[l-1][j];
        if (l < LEVELS) begin : g_p
          assign prop[l][j] = prop[l-1][j];
        end
      end
    end
  end

  assign clos = gen[LEVELS];

endmodule

FILE: rtl/wgm_checker.sv
// Port-level checks for the wildcard glob matcher, bound to the top level.
// Depends on wildcard_glob_matcher_core_defines.svh.
`include "wildcard_glob_matcher_core_defines.svh"

module wgm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  `WGM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `WGM_ASSERT_NOW(a_stall_only_when_full, !s_tready, m_tvalid)
  `WGM_ASSERT_NOW(a_result_after_last, $rose(m_tvalid),
                  $past(s_tvalid && s_tready && s_tlast))
  `WGM_ASSERT_NEXT(a_no_result_midstring, s_tvalid && s_tready && !s_tlast && !m_tvalid,
                   !m_tvalid)

endmodule

bind wildcard_glob_matcher_core wgm_checker u_wgm_checker (.*);
